@@ hw/rtl/rsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rsf_pkg: shared definitions for the ring spot filter
// Sizes, register indexes, verdict codes and the configuration record.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int MAX_SPOTS     = 64;
  localparam int COORD_BITS    = 16;
  localparam int SQP_BITS      = 2 * COORD_BITS;
  localparam int SQ_BITS       = 2 * COORD_BITS + 1;
  localparam int CNT_BITS      = $clog2(MAX_SPOTS + 1);
  localparam int IDX_BITS      = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SQ_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_X       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Y       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HALF       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_EXCLUSION = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SQ      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RING_BAND_SQ   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SEP_SQ     = 3'd6;

  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_OFF_RING  = 2'd1;
  localparam logic [1:0] VERDICT_TOO_CLOSE = 2'd2;
  localparam logic [1:0] VERDICT_FULL      = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_BITS-1:0]    sq_t;
  typedef logic [CNT_BITS-1:0]   count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  typedef struct packed {
    coord_t centre_x;
    coord_t centre_y;
    coord_t box_half;
    coord_t axis_exclusion;
    sq_t    radius_sq;
    sq_t    ring_band_sq;
    sq_t    min_separation_sq;
  } cfg_t;

endpackage

@@ hw/rtl/rsf_if.sv @@
// ----------------------------------------------------------------------------
// rsf_if: spot and result channels
// Valid/ready channels for incoming spot positions and filter results.
// ----------------------------------------------------------------------------
interface spot_if import rsf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t spot_x;
  coord_t spot_y;

  modport source (output valid, output spot_x, output spot_y, input ready);
  modport sink (input valid, input spot_x, input spot_y, output ready);
endinterface

interface result_if import rsf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] verdict;
  count_t     stored_count;

  modport source (output valid, output accepted, output verdict, output stored_count,
                  input ready);
  modport sink (input valid, input accepted, input verdict, input stored_count,
                output ready);
endinterface

@@ hw/rtl/rsf_spot_mem.sv @@
// ----------------------------------------------------------------------------
// rsf_spot_mem: stored spot positions
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rsf_spot_mem import rsf_pkg::*; (
  input  logic   clk,
  input  logic   we,
  input  idx_t   waddr,
  input  coord_t wdata_x,
  input  coord_t wdata_y,
  input  logic   re,
  input  idx_t   raddr,
  output coord_t rdata_x,
  output coord_t rdata_y
);

  logic [2*COORD_BITS-1:0] mem [MAX_SPOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdata_x, wdata_y};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      {rdata_x, rdata_y} <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rsf_dist_sq.sv @@
// ----------------------------------------------------------------------------
// rsf_dist_sq: squared distance pipeline
// Absolute offsets, squares and their sum over three register stages.
// ----------------------------------------------------------------------------
module rsf_dist_sq import rsf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  coord_t ax,
  input  coord_t ay,
  input  coord_t bx,
  input  coord_t by,
  output logic   out_valid,
  output sq_t    d2
);

  logic [2:0]          vpipe;
  coord_t              dx;
  coord_t              dy;
  logic [SQP_BITS-1:0] sqx;
  logic [SQP_BITS-1:0] sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dx  <= (ax >= bx) ? ax - bx : bx - ax;
    dy  <= (ay >= by) ? ay - by : by - ay;
    sqx <= SQP_BITS'(dx) * SQP_BITS'(dx);
    sqy <= SQP_BITS'(dy) * SQP_BITS'(dy);
    d2  <= SQ_BITS'(sqx) + SQ_BITS'(sqy);
  end

  assign out_valid = vpipe[2];

endmodule

@@ hw/rtl/rsf_ring_test.sv @@
// ----------------------------------------------------------------------------
// rsf_ring_test: ring membership test
// Box and axis checks alongside the squared radius, then the band compare.
// ----------------------------------------------------------------------------
module rsf_ring_test import rsf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  coord_t spot_x,
  input  coord_t spot_y,
  input  cfg_t   cfg,
  output logic   done,
  output logic   on_ring
);

  coord_t     ax;
  coord_t     ay;
  logic       geom_ok;
  logic [2:0] geom_pipe;
  logic       d_valid;
  sq_t        d2;
  sq_t        off;

  assign ax = (spot_x >= cfg.centre_x) ? spot_x - cfg.centre_x : cfg.centre_x - spot_x;
  assign ay = (spot_y >= cfg.centre_y) ? spot_y - cfg.centre_y : cfg.centre_y - spot_y;

  // Edges of the box and an offset equal to the exclusion both pass.
  assign geom_ok = (ax <= cfg.box_half) && (ay <= cfg.box_half) &&
                   (ax >= cfg.axis_exclusion) && (ay >= cfg.axis_exclusion);

  rsf_dist_sq u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .ax        (spot_x),
    .ay        (spot_y),
    .bx        (cfg.centre_x),
    .by        (cfg.centre_y),
    .out_valid (d_valid),
    .d2        (d2)
  );

  assign off = (d2 >= cfg.radius_sq) ? d2 - cfg.radius_sq : cfg.radius_sq - d2;

  always_ff @(posedge clk) begin
    geom_pipe <= {geom_pipe[1:0], geom_ok};
    on_ring   <= geom_pipe[2] && (off < cfg.ring_band_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
  end

endmodule

@@ hw/rtl/ring_spot_filter_with_separation.sv @@
// ----------------------------------------------------------------------------
// ring_spot_filter_with_separation: ring spot filter with separation check
// Accepts spots on a configured ring and keeps them at a minimum spacing.
// ----------------------------------------------------------------------------
// Each spot beat yields one result beat. A spot off the ring goes from the
// ring test straight to the final step, and so does a spot on the ring while
// the store is empty; for a spot on the ring with spots already stored, the
// stored positions are first read out of the spot memory one per cycle and
// run through the distance pipeline, which then drains. One spot is worked
// on at a time; a new spot is taken while the previous result still waits on
// the output register, and a stalled output holds back only the final step.
// No spot is taken during reset. The user must see that configuration is
// written only while no spot is in flight; the block does not enforce this.
module ring_spot_filter_with_separation import rsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  spot_if.sink                     spot_in,
  result_if.source                 result_out,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RING   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // Final drain count; the drain lasts until the hit flag of the last memory read is folded in.
  localparam logic [2:0] DRAIN_LAST = 3'd4;

  logic [2:0] state;
  cfg_t       cfg;
  coord_t     spot_x;
  coord_t     spot_y;
  logic       ring_ok;
  logic       too_close;
  idx_t       idx;
  logic [2:0] drain;
  count_t     count;
  logic       rd_valid;
  logic       hit_valid;
  logic       hit;

  logic       out_valid;
  logic       out_accepted;
  logic [1:0] out_verdict;
  count_t     out_count;

  logic       in_beat;
  logic       ring_done;
  logic       ring_pass;
  logic       mem_re;
  logic       mem_we;
  coord_t     rdata_x;
  coord_t     rdata_y;
  logic       d_valid;
  sq_t        d2;
  logic       last_issue;
  logic       out_free;
  logic       out_load;
  logic [1:0] verdict;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTRE_X:       cfg.centre_x          <= cfg_data[COORD_BITS-1:0];
        REG_CENTRE_Y:       cfg.centre_y          <= cfg_data[COORD_BITS-1:0];
        REG_BOX_HALF:       cfg.box_half          <= cfg_data[COORD_BITS-1:0];
        REG_AXIS_EXCLUSION: cfg.axis_exclusion    <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS_SQ:      cfg.radius_sq         <= cfg_data[SQ_BITS-1:0];
        REG_RING_BAND_SQ:   cfg.ring_band_sq      <= cfg_data[SQ_BITS-1:0];
        REG_MIN_SEP_SQ:     cfg.min_separation_sq <= cfg_data[SQ_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign spot_in.ready = (state == ST_IDLE) && !rst;
  assign in_beat       = spot_in.valid && spot_in.ready;

  rsf_ring_test u_ring (
    .clk     (clk),
    .rst     (rst),
    .start   (in_beat),
    .spot_x  (spot_in.spot_x),
    .spot_y  (spot_in.spot_y),
    .cfg     (cfg),
    .done    (ring_done),
    .on_ring (ring_pass)
  );

  // Reads of the store happen only in the scan, writes only in the final
  // step, so the two never touch the same entry in one cycle.
  assign mem_re     = (state == ST_SCAN);
  assign last_issue = ((CNT_BITS'(idx) + CNT_BITS'(1)) == count);

  rsf_spot_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (count[IDX_BITS-1:0]),
    .wdata_x (spot_x),
    .wdata_y (spot_y),
    .re      (mem_re),
    .raddr   (idx),
    .rdata_x (rdata_x),
    .rdata_y (rdata_y)
  );

  rsf_dist_sq u_sep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .ax        (rdata_x),
    .ay        (rdata_y),
    .bx        (spot_x),
    .by        (spot_y),
    .out_valid (d_valid),
    .d2        (d2)
  );

  always_ff @(posedge clk) begin
    hit <= (d2 < cfg.min_separation_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      rd_valid  <= mem_re;
      hit_valid <= d_valid;
    end
  end

  // Final verdict, in order of precedence.
  always_comb begin
    priority if (!ring_ok) begin
      verdict = VERDICT_OFF_RING;
    end else if (too_close) begin
      verdict = VERDICT_TOO_CLOSE;
    end else if (count >= CNT_BITS'(MAX_SPOTS)) begin
      verdict = VERDICT_FULL;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  assign out_free = !out_valid || result_out.ready;
  assign out_load = (state == ST_FINISH) && out_free;
  assign mem_we   = out_load && (verdict == VERDICT_OK);

  always_ff @(posedge clk) begin
    if (in_beat) begin
      spot_x <= spot_in.spot_x;
      spot_y <= spot_in.spot_y;
    end
    if (state == ST_RING && ring_done) begin
      ring_ok <= ring_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      too_close <= 1'b0;
      idx       <= '0;
      drain     <= '0;
      count     <= '0;
    end else begin
      if (hit_valid && hit) begin
        too_close <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            too_close <= 1'b0;
            state     <= ST_RING;
          end
        end
        ST_RING: begin
          if (ring_done) begin
            idx <= '0;
            if (ring_pass && count != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (last_issue) begin
            drain <= '0;
            state <= ST_DRAIN;
          end else begin
            idx <= idx + idx_t'(1);
          end
        end
        ST_DRAIN: begin
          if (drain == DRAIN_LAST) begin
            state <= ST_FINISH;
          end else begin
            drain <= drain + 3'd1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (verdict == VERDICT_OK) begin
              count <= count + CNT_BITS'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_accepted <= (verdict == VERDICT_OK);
      out_verdict  <= verdict;
      out_count    <= (verdict == VERDICT_OK) ? count + CNT_BITS'(1) : count;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.accepted     = out_accepted;
  assign result_out.verdict      = out_verdict;
  assign result_out.stored_count = out_count;

  a_write_fits: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (count < CNT_BITS'(MAX_SPOTS)))
    else $error("spot store written while full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (count == $past(count) + CNT_BITS'(1)))
    else $error("stored count did not advance after a store write");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (CNT_BITS'(idx) < count))
    else $error("scan read beyond the stored spots");

  a_ring_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    ring_done |-> (state == ST_RING))
    else $error("ring test finished outside its wait state");

  a_beat_starts_ring: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_RING))
    else $error("accepted spot did not start the ring test");

endmodule
